@@ hdl/lprg_pkg.sv @@
// Shared constants, types and arctangent table for the phase ramp generator.
package lprg_pkg;

  localparam int unsigned MAX_POINTS = 4096;
  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned ROT_STEPS  = 24;
  localparam int unsigned NUM_W      = 13;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned SHIFT_W    = 24;
  localparam int unsigned ROT_W      = 44;
  localparam int unsigned ANG_W      = 33;
  localparam int unsigned PROD_W     = 41;
  localparam int unsigned ADDR_W     = 4;

  localparam logic [ADDR_W-1:0] ADDR_NUM    = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_ORIGIN = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_SHIFT  = 4'h8;

  localparam logic signed [ROT_W-1:0] ROT_GAIN = 44'sd667681662976;

  typedef struct packed {
    logic                     vld;
    logic                     neg;
    logic                     beyond;
    logic [IDX_W-1:0]         idx;
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
  } rot_t;

  function automatic logic signed [ANG_W-1:0] atan_turn(input int unsigned k);
    logic signed [ANG_W-1:0] v;
    v = '0;
    case (k)
      0: v = 33'sd536870912;   1: v = 33'sd316933406;
      2: v = 33'sd167458907;   3: v = 33'sd85004756;
      4: v = 33'sd42667331;    5: v = 33'sd21354465;
      6: v = 33'sd10679838;    7: v = 33'sd5340245;
      8: v = 33'sd2670163;     9: v = 33'sd1335087;
      10: v = 33'sd667544;     11: v = 33'sd333772;
      12: v = 33'sd166886;     13: v = 33'sd83443;
      14: v = 33'sd41722;      15: v = 33'sd20861;
      16: v = 33'sd10430;      17: v = 33'sd5215;
      18: v = 33'sd2608;       19: v = 33'sd1304;
      20: v = 33'sd652;        21: v = 33'sd326;
      22: v = 33'sd163;        23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/linear_phase_ramp_generator.sv @@
// Pipeline: stage A, stage B, division cells, stage C, rotation cells, output reg.
// Throughput: one request per cycle; busy stays low, the cell chains take a new
// request every cycle (44 division cells, then 24 rotation cells).
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: registers return to N=2048, origin=1024, shift=0; in-flight requests drop.
// Top level of the linear phase ramp generator.
module linear_phase_ramp_generator #(
  parameter int unsigned MAX_POINTS = lprg_pkg::MAX_POINTS,
  parameter int unsigned OUT_BITS   = lprg_pkg::OUT_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lprg_pkg::IDX_W-1:0] point_index_i,
  output logic                       result_valid_o,
  output logic [lprg_pkg::IDX_W-1:0] point_echo_o,
  output logic signed [OUT_BITS-1:0] cos_part_o,
  output logic signed [OUT_BITS-1:0] sin_part_o,
  output logic                       index_beyond_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lprg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  localparam int unsigned IW = lprg_pkg::IDX_W;
  localparam int unsigned DW = lprg_pkg::NUM_W + 1;   // den 2N
  localparam int unsigned NW = lprg_pkg::ROT_W;       // dividend width
  localparam int unsigned MW = IW + 1;
  localparam int unsigned RW = lprg_pkg::ROT_W;
  localparam int unsigned SH = 40 - (OUT_BITS - 1);
  localparam int unsigned PW = lprg_pkg::PROD_W - 4;
  localparam int unsigned NUMW = lprg_pkg::NUM_W;

  logic [lprg_pkg::NUM_W-1:0]   num_q;
  logic [IW-1:0]                orig_q;
  logic [lprg_pkg::SHIFT_W-1:0] shift_q;
  logic                         wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= 13'd2048;
      orig_q  <= 12'd1024;
      shift_q <= '0;
    end else if (wr_en) begin
      case (paddr)
        lprg_pkg::ADDR_NUM:    num_q   <= pwdata[lprg_pkg::NUM_W-1:0];
        lprg_pkg::ADDR_ORIGIN: orig_q  <= pwdata[IW-1:0];
        lprg_pkg::ADDR_SHIFT:  shift_q <= pwdata[lprg_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      lprg_pkg::ADDR_NUM:    prdata = {19'd0, num_q};
      lprg_pkg::ADDR_ORIGIN: prdata = {20'd0, orig_q};
      lprg_pkg::ADDR_SHIFT:  prdata = {8'd0, shift_q};
      default:               prdata = '0;
    endcase
  end

  // Effective divisor
  logic [lprg_pkg::NUM_W-1:0] n_eff;
  always_comb begin
    if (num_q == '0) n_eff = 13'd1;
    else if (32'(num_q) > MAX_POINTS) n_eff = NUMW'(MAX_POINTS);
    else n_eff = num_q;
  end

  // Stage A: difference and flag
  logic               a_vld_q;
  logic signed [IW:0] a_d_q;
  logic [IW-1:0]      a_idx_q;
  logic               a_bey_q;
  logic [lprg_pkg::NUM_W-1:0] a_n_q;
  logic signed [lprg_pkg::SHIFT_W-1:0] a_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= start;
  end
  always_ff @(posedge clk_i) begin
    a_d_q   <= $signed({1'b0, point_index_i}) - $signed({1'b0, orig_q});
    a_idx_q <= point_index_i;
    a_bey_q <= ({1'b0, point_index_i} >= n_eff);
    a_n_q   <= n_eff;
    a_sh_q  <= $signed(shift_q);
  end

  // Stage B: product, then form 2P+N as sign/magnitude for the divider
  logic                   b_vld_q;
  logic signed [NW-1:0]   b_num_q;
  logic [IW-1:0]          b_idx_q;
  logic                   b_bey_q;
  logic [lprg_pkg::NUM_W-1:0] b_n_q;
  logic signed [PW-1:0] prod;
  assign prod = PW'(a_d_q) * PW'(a_sh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else         b_vld_q <= a_vld_q;
  end
  always_ff @(posedge clk_i) begin
    b_num_q <= NW'(prod) <<< 5;
    b_idx_q <= a_idx_q;
    b_bey_q <= a_bey_q;
    b_n_q   <= a_n_q;
  end

  // floor((2P+N)/(2N)) via magnitude division:
  // nonneg: Q = u/D ; neg: Q = -ceil(|u|/D) = -((|u|+D-1)/D)
  logic signed [NW-1:0] u;
  logic [NW-1:0]        mag;
  logic [DW-1:0]        den2;
  assign den2 = {b_n_q, 1'b0};
  assign u    = b_num_q + NW'(b_n_q);
  assign mag  = u[NW-1] ? (NW'(-u) + NW'(den2) - NW'(1)) : NW'(u);

  logic          dv_vld [NW+1];
  logic [NW-1:0] dv_num [NW+1];
  logic [DW:0]   dv_rem [NW+1];
  logic [DW-1:0] dv_den [NW+1];
  logic [MW:0]   dv_meta[NW+1];

  assign dv_vld[0]  = b_vld_q;
  assign dv_num[0]  = mag;
  assign dv_rem[0]  = '0;
  assign dv_den[0]  = den2;
  assign dv_meta[0] = {u[NW-1], b_bey_q, b_idx_q};

  for (genvar g = 0; g < NW; g++) begin : g_div
    lprg_div_cell #(.NUM_W(NW), .DEN_W(DW), .META_W(MW + 1)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(dv_vld[g]), .num_i(dv_num[g]), .rem_i(dv_rem[g]),
      .den_i(dv_den[g]), .meta_i(dv_meta[g]),
      .vld_o(dv_vld[g+1]), .num_o(dv_num[g+1]), .rem_o(dv_rem[g+1]),
      .den_o(dv_den[g+1]), .meta_o(dv_meta[g+1])
    );
  end

  // Stage C: angle and quadrant fold
  logic [19:0] qf;
  logic [19:0] negq;
  logic [31:0] ang;
  logic [31:0] angf;
  logic        fold;
  assign qf   = dv_meta[NW][MW] ? 20'(-dv_num[NW]) : dv_num[NW][19:0];
  assign negq = 20'(-qf);
  assign ang  = {negq, 12'd0};
  assign fold = (ang > 32'h4000_0000) && (ang <= 32'hC000_0000);
  assign angf = fold ? ang - 32'h8000_0000 : ang;

  lprg_pkg::rot_t rc[lprg_pkg::ROT_STEPS+1];
  lprg_pkg::rot_t c_d;
  lprg_pkg::rot_t c_q;

  always_comb begin
    c_d.vld    = dv_vld[NW];
    c_d.neg    = fold;
    c_d.beyond = dv_meta[NW][IW];
    c_d.idx    = dv_meta[NW][IW-1:0];
    c_d.x      = lprg_pkg::ROT_GAIN;
    c_d.y      = '0;
    c_d.z      = $signed({angf[31], angf});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_q <= '0;
    else         c_q <= c_d;
  end
  assign rc[0] = c_q;

  for (genvar s = 0; s < lprg_pkg::ROT_STEPS; s++) begin : g_rot
    lprg_rot_cell #(.STEP(s)) u_cell (.clk_i, .rst_ni, .in_i(rc[s]), .out_o(rc[s+1]));
  end

  // Output: sign fix, round, clamp
  lprg_pkg::rot_t fin;
  logic signed [RW-1:0] xf, yf, xr, yr;
  logic signed [OUT_BITS-1:0] xo, yo;
  localparam logic signed [RW-1:0] HI = RW'((64'sd1 <<< (OUT_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] LO = -HI - RW'(1);

  assign fin = rc[lprg_pkg::ROT_STEPS];
  assign xf  = fin.neg ? -fin.x : fin.x;
  assign yf  = fin.neg ? -fin.y : fin.y;
  assign xr  = (xf + (RW'(1) <<< (SH - 1))) >>> SH;
  assign yr  = (yf + (RW'(1) <<< (SH - 1))) >>> SH;
  assign xo  = (xr > HI) ? OUT_BITS'(HI) : (xr < LO) ? OUT_BITS'(LO) : OUT_BITS'(xr);
  assign yo  = (yr > HI) ? OUT_BITS'(HI) : (yr < LO) ? OUT_BITS'(LO) : OUT_BITS'(yr);

  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= fin.vld;
  end
  always_ff @(posedge clk_i) begin
    point_echo_o   <= fin.idx;
    cos_part_o     <= xo;
    sin_part_o     <= yo;
    index_beyond_o <= fin.beyond;
  end
  assign result_valid_o = vo_q;

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |=> dv_vld[1]) else $error("division chain dropped a request");
  a_rot_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_q.vld |=> rc[1].vld) else $error("rotation chain dropped a request");
  a_out_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.vld |=> result_valid_o) else $error("result lost");
`endif
endmodule

@@ hdl/lprg_div_cell.sv @@
// One restoring-division cell: settles one quotient bit and hands the rest on.
module lprg_div_cell #(
  parameter int unsigned NUM_W = 44,
  parameter int unsigned DEN_W = 14,
  parameter int unsigned META_W = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W:0]    rem_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [META_W-1:0] meta_i,
  output logic              vld_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [DEN_W:0]    rem_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [META_W-1:0] meta_o
);
  logic [DEN_W+1:0] trial;
  logic [DEN_W+1:0] diff;
  logic             vld_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W:0]    rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [META_W-1:0] meta_q;
  logic [NUM_W-1:0]  num_d;
  logic [DEN_W:0]    rem_d;

  always_comb begin
    trial = {rem_i, num_i[NUM_W-1]};
    diff  = trial - {2'b00, den_i};
    if (!diff[DEN_W+1]) begin
      rem_d = diff[DEN_W:0];
      num_d = {num_i[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DEN_W:0];
      num_d = {num_i[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_i;
    meta_q <= meta_i;
  end

  assign vld_o  = vld_q;
  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign meta_o = meta_q;
endmodule

@@ hdl/lprg_rot_cell.sv @@
// One rotation cell: a single CORDIC micro-rotation with its own registers.
module lprg_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lprg_pkg::rot_t in_i,
  output lprg_pkg::rot_t out_o
);
  lprg_pkg::rot_t cur_d;
  lprg_pkg::rot_t cur_q;
  logic signed [lprg_pkg::ROT_W-1:0] xs;
  logic signed [lprg_pkg::ROT_W-1:0] ys;

  always_comb begin
    xs = in_i.x >>> STEP;
    ys = in_i.y >>> STEP;
    cur_d = in_i;
    if (!in_i.z[lprg_pkg::ANG_W-1]) begin
      cur_d.x = in_i.x - ys;
      cur_d.y = in_i.y + xs;
      cur_d.z = in_i.z - lprg_pkg::atan_turn(STEP);
    end else begin
      cur_d.x = in_i.x + ys;
      cur_d.y = in_i.y - xs;
      cur_d.z = in_i.z + lprg_pkg::atan_turn(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  assign out_o = cur_q;
endmodule

@@ tb/sv/lprg_checker.sv @@
// Result checker: predicts each phasor from the accepted point index and compares.
module lprg_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic [lprg_pkg::IDX_W-1:0] point_index_i,
  input  logic                       result_valid_o,
  input  logic [lprg_pkg::IDX_W-1:0] point_echo_o,
  input  logic signed [15:0]         cos_part_o,
  input  logic signed [15:0]         sin_part_o,
  input  logic                       index_beyond_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [lprg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output int                         fail_count,
  output int                         pending_count,
  output int                         result_count
);
  typedef struct packed {
    logic [lprg_pkg::IDX_W-1:0] echo;
    logic signed [15:0]         re;
    logic signed [15:0]         im;
    logic                       beyond;
  } phasor_t;

  phasor_t                      phasor_q[$];
  logic [lprg_pkg::NUM_W-1:0]   n_reg;
  logic [lprg_pkg::IDX_W-1:0]   org_reg;
  logic [lprg_pkg::SHIFT_W-1:0] shift_reg;

  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + (longint'(1) <<< 24)) >>> 25;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic phasor_t predict_phasor(input logic [lprg_pkg::IDX_W-1:0] idx);
    longint n, sh, p, q, num, den, x, y, z, xs, ys;
    longint tbl[24];
    logic [31:0] ang;
    logic neg;
    phasor_t r;
    tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215,
            2608, 1304, 652, 326, 163, 81};
    n = n_reg;
    if (n == 0) n = 1;
    if (n > lprg_pkg::MAX_POINTS) n = lprg_pkg::MAX_POINTS;
    sh = longint'($signed(shift_reg));
    p = (longint'(idx) - longint'(org_reg)) * sh * 16;
    num = 2 * p + n;
    den = 2 * n;
    q = num / den;
    if (num % den != 0 && num < 0) q = q - 1;
    ang = {(-q[19:0]), 12'h000};
    neg = 1'b0;
    if (ang > 32'h4000_0000 && ang <= 32'hC000_0000) begin
      ang = ang - 32'h8000_0000;
      neg = 1'b1;
    end
    z = longint'($signed(ang));
    x = 64'd652032874 * 1024;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - tbl[i];
      end else begin
        x = x + ys; y = y - xs; z = z + tbl[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    r.echo = idx;
    r.re = round_q15(x);
    r.im = round_q15(y);
    r.beyond = (longint'(idx) >= n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    phasor_t e;
    if (!rst_ni) begin
      n_reg <= 13'd2048;
      org_reg <= 12'd1024;
      shift_reg <= '0;
      phasor_q.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          lprg_pkg::ADDR_NUM:    n_reg <= pwdata[lprg_pkg::NUM_W-1:0];
          lprg_pkg::ADDR_ORIGIN: org_reg <= pwdata[lprg_pkg::IDX_W-1:0];
          lprg_pkg::ADDR_SHIFT:  shift_reg <= pwdata[lprg_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        result_count <= result_count + 1;
        if (phasor_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result for point %0d", point_echo_o);
        end else begin
          e = phasor_q.pop_front();
          if (e.echo !== point_echo_o || e.re !== cos_part_o || e.im !== sin_part_o
              || e.beyond !== index_beyond_o) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp pt %0d cos %0d sin %0d bey %0b, got %0d %0d %0d %0b",
                       e.echo, e.re, e.im, e.beyond, point_echo_o, cos_part_o,
                       sin_part_o, index_beyond_o);
          end
        end
      end
      if (start && !busy) phasor_q.push_back(predict_phasor(point_index_i));
      pending_count <= phasor_q.size();
    end
  end
endmodule

@@ tb/sv/tb_linear_phase_ramp_generator.sv @@
// Testbench top: drives point requests and register writes, reports the verdict.
module tb_linear_phase_ramp_generator;
  localparam int LATENCY = 80;
  localparam int WATCHDOG = 2000;

  logic clk_i, rst_ni, start, busy, result_valid_o, index_beyond_o;
  logic [lprg_pkg::IDX_W-1:0] point_index_i, point_echo_o;
  logic signed [15:0] cos_part_o, sin_part_o;
  logic psel, penable, pwrite, pready;
  logic [lprg_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending_count, result_count, sent_count, idle_pct, quiet;

  linear_phase_ramp_generator dut (.*);

  lprg_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o || (start && !busy)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired after %0d results", result_count);
      $display("** linear_phase_ramp_generator: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [lprg_pkg::ADDR_W-1:0] a, input logic [31:0] d);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic set_ramp(input int n, input int org, input int sh);
    drain();
    write_reg(lprg_pkg::ADDR_NUM, n);
    write_reg(lprg_pkg::ADDR_ORIGIN, org);
    write_reg(lprg_pkg::ADDR_SHIFT, sh & 32'hFF_FFFF);
  endtask

  // Request one point; hold start until accepted, with optional idle gap first.
  task automatic send_point(input logic [lprg_pkg::IDX_W-1:0] idx);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    point_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic idle_line();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  initial begin
    int n;
    rst_ni = 1'b0; start = 1'b0; point_index_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0; sent_count = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: reset values, index extremes, zero and oversized N, shift extremes.
    send_point(12'd0); send_point(12'hFFF); send_point(12'd1024); send_point(12'd2048);
    idle_line();
    set_ramp(2048, 1024, 24'h010000);
    send_point(12'd0); send_point(12'd1023); send_point(12'd1024); send_point(12'd1536);
    send_point(12'd4095);
    idle_line();
    set_ramp(0, 0, -8388608);
    send_point(12'd0); send_point(12'd1); send_point(12'd4095);
    idle_line();
    set_ramp(8191, 4095, 8388607);
    send_point(12'd0); send_point(12'd4095); send_point(12'd2048); send_point(12'hAAA);
    idle_line();
    set_ramp(1, 0, 24'h008000);
    send_point(12'd0); send_point(12'd1); send_point(12'd3); send_point(12'h555);
    idle_line();
    set_ramp(4096, 0, 24'h000001);
    send_point(12'd4095); send_point(12'd0);
    idle_line();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 84;
        2: idle_pct = 10;
        default: idle_pct = 50;
      endcase
      if (ph == 3) set_ramp(1, 4095, 8388607);
      else if (ph == 6) set_ramp(4096, 2048, -8388608);
      else if (ph == 7) set_ramp(0, $urandom_range(4095, 0), $urandom);
      else begin
        n = $urandom_range(4096, 1);
        if (ph % 2) n = $urandom_range(8191, 0);
        set_ramp(n, $urandom_range(4095, 0), $urandom);
      end
      for (int i = 0; i < 205; i++) send_point(12'($urandom_range(4095, 0)));
      idle_line();
    end

    drain();
    $display("%0d point requests over several register settings, %0d results checked",
             sent_count, result_count);
    if (fail_count == 0) $display("** linear_phase_ramp_generator: PASSED **");
    else $display("** linear_phase_ramp_generator: FAILED **");
    $finish;
  end
endmodule
